### rtl/rpp_pkg.sv
// package: fixed-point types, constants and arithmetic helpers for the point projection
`timescale 1ns / 1ps
`default_nettype none
package rpp_pkg;

  localparam int IMG_COLS = 1024;
  localparam int IMG_ROWS = 768;

  localparam int CFG_IDX_W   = 4;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = 64 / DIV_BITS;
  localparam int PIPE_N      = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANG_P1 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANG_P2 = 4'd7;

  localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

  typedef logic signed [63:0] q_t;

  localparam logic [62:0] QCAP = '1;
  localparam logic signed [64:0] QMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] QMIN65 = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
  localparam q_t Q_TWO = 64'sh0000_0002_0000_0000;
  localparam logic [63:0] IZ_DIVIDEND = 64'h0001_0000_0000_0000;

  localparam logic signed [48:0] IMG_U_MAX = 49'(IMG_COLS - 1) << 16;
  localparam logic signed [48:0] IMG_V_MAX = 49'(IMG_ROWS - 1) << 16;

  typedef struct packed {
    logic        neg;
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } pp_t;

  function automatic logic [63:0] magn(q_t a);
    magn = a[63] ? 64'(-a) : 64'(a);
  endfunction

  // first half of a saturating q32.32 multiply: sign and partial products
  function automatic pp_t qmul_pp(q_t a, q_t b);
    logic [63:0] ma;
    logic [63:0] mb;
    pp_t p;
    ma = magn(a);
    mb = magn(b);
    p.neg = a[63] ^ b[63];
    p.hh = 64'(ma[63:32]) * 64'(mb[63:32]);
    p.hl = 64'(ma[63:32]) * 64'(mb[31:0]);
    p.lh = 64'(ma[31:0]) * 64'(mb[63:32]);
    p.ll = 64'(ma[31:0]) * 64'(mb[31:0]);
    qmul_pp = p;
  endfunction

  // second half: sum partial products, truncate, saturate
  function automatic q_t qmul_fin(pp_t p);
    logic [65:0] r;
    logic [62:0] m;
    r = {p.hh[33:0], 32'b0} + 66'(p.hl) + 66'(p.lh) + 66'(p.ll[63:32]);
    if (p.hh > 64'h7FFF_FFFF || r > 66'(QCAP)) begin
      m = QCAP;
    end else begin
      m = r[62:0];
    end
    qmul_fin = p.neg ? -q_t'({1'b0, m}) : q_t'({1'b0, m});
  endfunction

  function automatic q_t qadd(q_t a, q_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > QMAX65) begin
      qadd = QMAX65[63:0];
    end else if (s < QMIN65) begin
      qadd = QMIN65[63:0];
    end else begin
      qadd = s[63:0];
    end
  endfunction

  // q32.32 to saturated q16.16, truncated toward zero
  function automatic logic signed [31:0] to_q16(q_t a);
    logic [63:0] m;
    m = magn(a) >> 16;
    if (a[63]) begin
      to_q16 = (m > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
    end else begin
      to_q16 = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
    end
  endfunction

endpackage
`default_nettype wire

### rtl/rpp_ifs.sv
// interfaces: configuration write channel, point input channel, projection result channel
`timescale 1ns / 1ps
`default_nettype none
interface rpp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rpp_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface rpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rpp_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               in_image;
  logic signed [31:0] jac_u_x;
  logic signed [31:0] jac_u_y;
  logic signed [31:0] jac_u_z;
  logic signed [31:0] jac_v_x;
  logic signed [31:0] jac_v_y;
  logic signed [31:0] jac_v_z;
  modport source (output valid, output valid_res, output pixel_u, output pixel_v,
                  output in_image, output jac_u_x, output jac_u_y, output jac_u_z,
                  output jac_v_x, output jac_v_y, output jac_v_z, input ready);
  modport sink (input valid, input valid_res, input pixel_u, input pixel_v,
                input in_image, input jac_u_x, input jac_u_y, input jac_u_z,
                input jac_v_x, input jac_v_y, input jac_v_z, output ready);
endinterface
`default_nettype wire

### rtl/rpp_div.sv
// pipelined restoring divider giving a saturated signed q32.32 quotient
`timescale 1ns / 1ps
`default_nettype none
module rpp_div (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [63:0]   dividend_i,
  input  wire logic [30:0]   divisor_i,
  input  wire logic          neg_i,
  output rpp_pkg::q_t        quo_o
);

  logic [63:0] work_q [rpp_pkg::DIV_STAGES];
  logic [63:0] work_d [rpp_pkg::DIV_STAGES];
  logic [30:0] rem_q  [rpp_pkg::DIV_STAGES];
  logic [30:0] rem_d  [rpp_pkg::DIV_STAGES];
  logic [30:0] den_q  [rpp_pkg::DIV_STAGES];
  logic [30:0] den_d  [rpp_pkg::DIV_STAGES];
  logic        neg_q  [rpp_pkg::DIV_STAGES];
  logic        neg_d  [rpp_pkg::DIV_STAGES];
  logic [62:0] mag;

  always_comb begin
    logic [31:0] trial;
    trial = '0;
    for (int s = 0; s < rpp_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        work_d[s] = dividend_i;
        rem_d[s]  = '0;
        den_d[s]  = divisor_i;
        neg_d[s]  = neg_i;
      end else begin
        work_d[s] = work_q[s-1];
        rem_d[s]  = rem_q[s-1];
        den_d[s]  = den_q[s-1];
        neg_d[s]  = neg_q[s-1];
      end
      for (int b = 0; b < rpp_pkg::DIV_BITS; b++) begin
        trial = {rem_d[s], work_d[s][63]};
        work_d[s] = {work_d[s][62:0], 1'b0};
        if (trial >= {1'b0, den_d[s]}) begin
          rem_d[s] = 31'(trial - {1'b0, den_d[s]});
          work_d[s][0] = 1'b1;
        end else begin
          rem_d[s] = trial[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      neg_q  <= neg_d;
    end
  end

  assign mag = work_q[rpp_pkg::DIV_STAGES-1][63] ? rpp_pkg::QCAP
                                                 : work_q[rpp_pkg::DIV_STAGES-1][62:0];
  assign quo_o = neg_q[rpp_pkg::DIV_STAGES-1] ? -rpp_pkg::q_t'({1'b0, mag})
                                              : rpp_pkg::q_t'({1'b0, mag});

endmodule
`default_nettype wire

### rtl/radtan_point_projection.sv
// top level: radial-tangential pinhole projection of one point per item with jacobian
//
//   channel  dir  handshake      payload
//   cfg_i    in   valid/ready    index, data (register write)
//   pnt_i    in   valid/ready    point_x, point_y, point_z
//   res_o    out  valid/ready    valid_res, pixel, in_image, six jacobian terms
//
// one item per cycle while res_o does not stall; 16 divider stages, 20 arithmetic stages;
// each multiply is split into a partial-product stage and a finishing stage
// cfg_i is always ready; the user must see that registers are written while no item
// is in flight, which the block does not enforce; rst_ni clears valid bits and the
// registers to their reset values; a stall at res_o holds the whole pipeline;
// pnt_i.ready drops only when the output register is full and not taken
`timescale 1ns / 1ps
`default_nettype none
module radtan_point_projection (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rpp_cfg_if.sink    cfg_i,
  rpp_in_if.sink     pnt_i,
  rpp_out_if.source  res_o
);

  typedef struct packed {
    logic               ok;
    rpp_pkg::q_t        xn, yn, iz;
    rpp_pkg::q_t        x2, y2, xy, nx, ny;
    rpp_pkg::q_t        tp1yn, sp2xn, tp1xn, tp2yn, tp2xn, sp1yn;
    rpp_pkg::q_t        r2, txx, tyy, tk1x2, tk1y2, tk1xy, txy1, txy2;
    rpp_pkg::q_t        k1r2, k2r2, fk2r2, ax, ay;
    rpp_pkg::q_t        k2r2r2, f4x2, f4y2, f4xy, p2ax, p1ay;
    rpp_pkg::q_t        rad, xrad, yrad, d00, d01, d11, xd, yd;
    rpp_pkg::q_t        fxd, fyd, g00, g01, g10, g11;
    rpp_pkg::q_t        j0, j1, j2, j3, j4, j5, j6, j7;
    logic signed [31:0] pu, pv;
    logic               inimg;
    logic signed [31:0] ju_x, ju_y, ju_z, jv_x, jv_y, jv_z;
    rpp_pkg::pp_t [10:0] pp;
  } stage_t;

  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [31:0] radial_k1_q, radial_k2_q, tang_p1_q, tang_p2_q;

  rpp_pkg::q_t fx, fy, cx, cy, k1, k2, p1, p2;
  rpp_pkg::q_t tk1, fk2, tp1, tp2, sp1, sp2;
  logic        dist_on;
  logic        en;

  logic [rpp_pkg::DIV_STAGES-1:0] vdiv_q;
  logic [rpp_pkg::DIV_STAGES-1:0] okdiv_q;
  logic [rpp_pkg::PIPE_N-1:0]     vld_q;
  stage_t                         pipe_q [rpp_pkg::PIPE_N];
  stage_t                         pipe_d [rpp_pkg::PIPE_N];

  rpp_pkg::q_t xn_div, yn_div, iz_div;
  logic [31:0] mag_x, mag_y;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= rpp_pkg::FOCAL_RESET;
      focal_y_q   <= rpp_pkg::FOCAL_RESET;
      center_x_q  <= '0;
      center_y_q  <= '0;
      radial_k1_q <= '0;
      radial_k2_q <= '0;
      tang_p1_q   <= '0;
      tang_p2_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rpp_pkg::REG_FOCAL_X:   focal_x_q   <= cfg_i.data;
        rpp_pkg::REG_FOCAL_Y:   focal_y_q   <= cfg_i.data;
        rpp_pkg::REG_CENTER_X:  center_x_q  <= cfg_i.data;
        rpp_pkg::REG_CENTER_Y:  center_y_q  <= cfg_i.data;
        rpp_pkg::REG_RADIAL_K1: radial_k1_q <= cfg_i.data;
        rpp_pkg::REG_RADIAL_K2: radial_k2_q <= cfg_i.data;
        rpp_pkg::REG_TANG_P1:   tang_p1_q   <= cfg_i.data;
        rpp_pkg::REG_TANG_P2:   tang_p2_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // register values in q32.32
  assign fx  = {16'b0, focal_x_q, 16'b0};
  assign fy  = {16'b0, focal_y_q, 16'b0};
  assign cx  = {{16{center_x_q[31]}}, center_x_q, 16'b0};
  assign cy  = {{16{center_y_q[31]}}, center_y_q, 16'b0};
  assign k1  = {{28{radial_k1_q[31]}}, radial_k1_q, 4'b0};
  assign k2  = {{28{radial_k2_q[31]}}, radial_k2_q, 4'b0};
  assign p1  = {{28{tang_p1_q[31]}}, tang_p1_q, 4'b0};
  assign p2  = {{28{tang_p2_q[31]}}, tang_p2_q, 4'b0};
  assign tk1 = {{27{radial_k1_q[31]}}, radial_k1_q, 5'b0};
  assign fk2 = {{26{radial_k2_q[31]}}, radial_k2_q, 6'b0};
  assign tp1 = {{27{tang_p1_q[31]}}, tang_p1_q, 5'b0};
  assign tp2 = {{27{tang_p2_q[31]}}, tang_p2_q, 5'b0};
  assign sp1 = tp1 + {{26{tang_p1_q[31]}}, tang_p1_q, 6'b0};
  assign sp2 = tp2 + {{26{tang_p2_q[31]}}, tang_p2_q, 6'b0};

  assign dist_on = !radial_k1_q[31] && (|radial_k1_q) && !radial_k2_q[31] && (|radial_k2_q)
                && !tang_p1_q[31] && (|tang_p1_q) && !tang_p2_q[31] && (|tang_p2_q);

  // global advance: the pipe moves unless the output item is held
  assign en          = !vld_q[rpp_pkg::PIPE_N-1] || res_o.ready;
  assign pnt_i.ready = en;

  // dividers
  assign mag_x = 32'(rpp_pkg::magn(64'(pnt_i.point_x)));
  assign mag_y = 32'(rpp_pkg::magn(64'(pnt_i.point_y)));

  rpp_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({mag_x, 32'b0}),
    .divisor_i  (pnt_i.point_z[30:0]),
    .neg_i      (pnt_i.point_x[31]),
    .quo_o      (xn_div)
  );

  rpp_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({mag_y, 32'b0}),
    .divisor_i  (pnt_i.point_z[30:0]),
    .neg_i      (pnt_i.point_y[31]),
    .quo_o      (yn_div)
  );

  rpp_div u_div_z (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (rpp_pkg::IZ_DIVIDEND),
    .divisor_i  (pnt_i.point_z[30:0]),
    .neg_i      (1'b0),
    .quo_o      (iz_div)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      okdiv_q <= {okdiv_q[rpp_pkg::DIV_STAGES-2:0],
                  !pnt_i.point_z[31] && (|pnt_i.point_z)};
      pipe_q  <= pipe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdiv_q <= '0;
      vld_q  <= '0;
    end else if (en) begin
      vdiv_q <= {vdiv_q[rpp_pkg::DIV_STAGES-2:0], pnt_i.valid};
      vld_q  <= {vld_q[rpp_pkg::PIPE_N-2:0], vdiv_q[rpp_pkg::DIV_STAGES-1]};
    end
  end

  // arithmetic stages
  always_comb begin
    pipe_d[0]    = pipe_q[0];
    pipe_d[0].ok = okdiv_q[rpp_pkg::DIV_STAGES-1];
    pipe_d[0].xn = xn_div;
    pipe_d[0].yn = yn_div;
    pipe_d[0].iz = iz_div;
    for (int s = 1; s < rpp_pkg::PIPE_N; s++) begin
      pipe_d[s] = pipe_q[s-1];
    end

    pipe_d[1].pp[0]  = rpp_pkg::qmul_pp(pipe_q[0].xn, pipe_q[0].xn);
    pipe_d[1].pp[1]  = rpp_pkg::qmul_pp(pipe_q[0].yn, pipe_q[0].yn);
    pipe_d[1].pp[2]  = rpp_pkg::qmul_pp(pipe_q[0].xn, pipe_q[0].yn);
    pipe_d[1].pp[3]  = rpp_pkg::qmul_pp(pipe_q[0].xn, pipe_q[0].iz);
    pipe_d[1].pp[4]  = rpp_pkg::qmul_pp(pipe_q[0].yn, pipe_q[0].iz);
    pipe_d[1].pp[5]  = rpp_pkg::qmul_pp(tp1, pipe_q[0].yn);
    pipe_d[1].pp[6]  = rpp_pkg::qmul_pp(sp2, pipe_q[0].xn);
    pipe_d[1].pp[7]  = rpp_pkg::qmul_pp(tp1, pipe_q[0].xn);
    pipe_d[1].pp[8]  = rpp_pkg::qmul_pp(tp2, pipe_q[0].yn);
    pipe_d[1].pp[9]  = rpp_pkg::qmul_pp(tp2, pipe_q[0].xn);
    pipe_d[1].pp[10] = rpp_pkg::qmul_pp(sp1, pipe_q[0].yn);

    pipe_d[2].x2    = rpp_pkg::qmul_fin(pipe_q[1].pp[0]);
    pipe_d[2].y2    = rpp_pkg::qmul_fin(pipe_q[1].pp[1]);
    pipe_d[2].xy    = rpp_pkg::qmul_fin(pipe_q[1].pp[2]);
    pipe_d[2].nx    = -rpp_pkg::qmul_fin(pipe_q[1].pp[3]);
    pipe_d[2].ny    = -rpp_pkg::qmul_fin(pipe_q[1].pp[4]);
    pipe_d[2].tp1yn = rpp_pkg::qmul_fin(pipe_q[1].pp[5]);
    pipe_d[2].sp2xn = rpp_pkg::qmul_fin(pipe_q[1].pp[6]);
    pipe_d[2].tp1xn = rpp_pkg::qmul_fin(pipe_q[1].pp[7]);
    pipe_d[2].tp2yn = rpp_pkg::qmul_fin(pipe_q[1].pp[8]);
    pipe_d[2].tp2xn = rpp_pkg::qmul_fin(pipe_q[1].pp[9]);
    pipe_d[2].sp1yn = rpp_pkg::qmul_fin(pipe_q[1].pp[10]);

    pipe_d[3].r2    = rpp_pkg::qadd(pipe_q[2].x2, pipe_q[2].y2);
    pipe_d[3].pp[0] = rpp_pkg::qmul_pp(rpp_pkg::Q_TWO, pipe_q[2].x2);
    pipe_d[3].pp[1] = rpp_pkg::qmul_pp(rpp_pkg::Q_TWO, pipe_q[2].y2);
    pipe_d[3].pp[2] = rpp_pkg::qmul_pp(tk1, pipe_q[2].x2);
    pipe_d[3].pp[3] = rpp_pkg::qmul_pp(tk1, pipe_q[2].y2);
    pipe_d[3].pp[4] = rpp_pkg::qmul_pp(tk1, pipe_q[2].xy);
    pipe_d[3].pp[5] = rpp_pkg::qmul_pp(tp1, pipe_q[2].xy);
    pipe_d[3].pp[6] = rpp_pkg::qmul_pp(tp2, pipe_q[2].xy);

    pipe_d[4].txx   = rpp_pkg::qmul_fin(pipe_q[3].pp[0]);
    pipe_d[4].tyy   = rpp_pkg::qmul_fin(pipe_q[3].pp[1]);
    pipe_d[4].tk1x2 = rpp_pkg::qmul_fin(pipe_q[3].pp[2]);
    pipe_d[4].tk1y2 = rpp_pkg::qmul_fin(pipe_q[3].pp[3]);
    pipe_d[4].tk1xy = rpp_pkg::qmul_fin(pipe_q[3].pp[4]);
    pipe_d[4].txy1  = rpp_pkg::qmul_fin(pipe_q[3].pp[5]);
    pipe_d[4].txy2  = rpp_pkg::qmul_fin(pipe_q[3].pp[6]);

    pipe_d[5].pp[0] = rpp_pkg::qmul_pp(k1, pipe_q[4].r2);
    pipe_d[5].pp[1] = rpp_pkg::qmul_pp(k2, pipe_q[4].r2);
    pipe_d[5].pp[2] = rpp_pkg::qmul_pp(fk2, pipe_q[4].r2);
    pipe_d[5].ax    = rpp_pkg::qadd(pipe_q[4].r2, pipe_q[4].txx);
    pipe_d[5].ay    = rpp_pkg::qadd(pipe_q[4].r2, pipe_q[4].tyy);

    pipe_d[6].k1r2  = rpp_pkg::qmul_fin(pipe_q[5].pp[0]);
    pipe_d[6].k2r2  = rpp_pkg::qmul_fin(pipe_q[5].pp[1]);
    pipe_d[6].fk2r2 = rpp_pkg::qmul_fin(pipe_q[5].pp[2]);

    pipe_d[7].pp[0] = rpp_pkg::qmul_pp(pipe_q[6].k2r2, pipe_q[6].r2);
    pipe_d[7].pp[1] = rpp_pkg::qmul_pp(pipe_q[6].fk2r2, pipe_q[6].x2);
    pipe_d[7].pp[2] = rpp_pkg::qmul_pp(pipe_q[6].fk2r2, pipe_q[6].y2);
    pipe_d[7].pp[3] = rpp_pkg::qmul_pp(pipe_q[6].fk2r2, pipe_q[6].xy);
    pipe_d[7].pp[4] = rpp_pkg::qmul_pp(p2, pipe_q[6].ax);
    pipe_d[7].pp[5] = rpp_pkg::qmul_pp(p1, pipe_q[6].ay);

    pipe_d[8].k2r2r2 = rpp_pkg::qmul_fin(pipe_q[7].pp[0]);
    pipe_d[8].f4x2   = rpp_pkg::qmul_fin(pipe_q[7].pp[1]);
    pipe_d[8].f4y2   = rpp_pkg::qmul_fin(pipe_q[7].pp[2]);
    pipe_d[8].f4xy   = rpp_pkg::qmul_fin(pipe_q[7].pp[3]);
    pipe_d[8].p2ax   = rpp_pkg::qmul_fin(pipe_q[7].pp[4]);
    pipe_d[8].p1ay   = rpp_pkg::qmul_fin(pipe_q[7].pp[5]);

    pipe_d[9].rad = rpp_pkg::qadd(pipe_q[8].k1r2, pipe_q[8].k2r2r2);
    pipe_d[9].d01 = rpp_pkg::qadd(pipe_q[8].tk1xy, pipe_q[8].f4xy);

    pipe_d[10].pp[0] = rpp_pkg::qmul_pp(pipe_q[9].xn, pipe_q[9].rad);
    pipe_d[10].pp[1] = rpp_pkg::qmul_pp(pipe_q[9].yn, pipe_q[9].rad);
    pipe_d[10].d00   = rpp_pkg::qadd(rpp_pkg::Q_ONE, pipe_q[9].rad);
    pipe_d[10].d11   = rpp_pkg::qadd(rpp_pkg::Q_ONE, pipe_q[9].rad);
    pipe_d[10].d01   = rpp_pkg::qadd(pipe_q[9].d01, pipe_q[9].tp1xn);

    pipe_d[11].xrad = rpp_pkg::qmul_fin(pipe_q[10].pp[0]);
    pipe_d[11].yrad = rpp_pkg::qmul_fin(pipe_q[10].pp[1]);
    pipe_d[11].d00  = rpp_pkg::qadd(pipe_q[10].d00, pipe_q[10].tk1x2);
    pipe_d[11].d11  = rpp_pkg::qadd(pipe_q[10].d11, pipe_q[10].tk1y2);
    pipe_d[11].d01  = rpp_pkg::qadd(pipe_q[10].d01, pipe_q[10].tp2yn);

    pipe_d[12].xd  = rpp_pkg::qadd(pipe_q[11].xrad, pipe_q[11].txy1);
    pipe_d[12].yd  = rpp_pkg::qadd(pipe_q[11].yrad, pipe_q[11].txy2);
    pipe_d[12].d00 = rpp_pkg::qadd(pipe_q[11].d00, pipe_q[11].f4x2);
    pipe_d[12].d11 = rpp_pkg::qadd(pipe_q[11].d11, pipe_q[11].f4y2);

    pipe_d[13].xd  = rpp_pkg::qadd(pipe_q[12].xd, pipe_q[12].p2ax);
    pipe_d[13].yd  = rpp_pkg::qadd(pipe_q[12].yd, pipe_q[12].p1ay);
    pipe_d[13].d00 = rpp_pkg::qadd(pipe_q[12].d00, pipe_q[12].tp1yn);
    pipe_d[13].d11 = rpp_pkg::qadd(pipe_q[12].d11, pipe_q[12].tp2xn);

    // distortion applied to the pixel only when all coefficients are positive
    pipe_d[14].xd  = dist_on ? rpp_pkg::qadd(pipe_q[13].xn, pipe_q[13].xd) : pipe_q[13].xn;
    pipe_d[14].yd  = dist_on ? rpp_pkg::qadd(pipe_q[13].yn, pipe_q[13].yd) : pipe_q[13].yn;
    pipe_d[14].d00 = rpp_pkg::qadd(pipe_q[13].d00, pipe_q[13].sp2xn);
    pipe_d[14].d11 = rpp_pkg::qadd(pipe_q[13].d11, pipe_q[13].sp1yn);

    pipe_d[15].pp[0] = rpp_pkg::qmul_pp(fx, pipe_q[14].xd);
    pipe_d[15].pp[1] = rpp_pkg::qmul_pp(fy, pipe_q[14].yd);
    pipe_d[15].pp[2] = rpp_pkg::qmul_pp(fx, pipe_q[14].d00);
    pipe_d[15].pp[3] = rpp_pkg::qmul_pp(fx, pipe_q[14].d01);
    pipe_d[15].pp[4] = rpp_pkg::qmul_pp(fy, pipe_q[14].d01);
    pipe_d[15].pp[5] = rpp_pkg::qmul_pp(fy, pipe_q[14].d11);

    pipe_d[16].fxd = rpp_pkg::qmul_fin(pipe_q[15].pp[0]);
    pipe_d[16].fyd = rpp_pkg::qmul_fin(pipe_q[15].pp[1]);
    pipe_d[16].g00 = rpp_pkg::qmul_fin(pipe_q[15].pp[2]);
    pipe_d[16].g01 = rpp_pkg::qmul_fin(pipe_q[15].pp[3]);
    pipe_d[16].g10 = rpp_pkg::qmul_fin(pipe_q[15].pp[4]);
    pipe_d[16].g11 = rpp_pkg::qmul_fin(pipe_q[15].pp[5]);

    pipe_d[17].pu    = rpp_pkg::to_q16(rpp_pkg::qadd(pipe_q[16].fxd, cx));
    pipe_d[17].pv    = rpp_pkg::to_q16(rpp_pkg::qadd(pipe_q[16].fyd, cy));
    pipe_d[17].pp[0] = rpp_pkg::qmul_pp(pipe_q[16].g00, pipe_q[16].iz);
    pipe_d[17].pp[1] = rpp_pkg::qmul_pp(pipe_q[16].g01, pipe_q[16].iz);
    pipe_d[17].pp[2] = rpp_pkg::qmul_pp(pipe_q[16].g00, pipe_q[16].nx);
    pipe_d[17].pp[3] = rpp_pkg::qmul_pp(pipe_q[16].g01, pipe_q[16].ny);
    pipe_d[17].pp[4] = rpp_pkg::qmul_pp(pipe_q[16].g10, pipe_q[16].iz);
    pipe_d[17].pp[5] = rpp_pkg::qmul_pp(pipe_q[16].g11, pipe_q[16].iz);
    pipe_d[17].pp[6] = rpp_pkg::qmul_pp(pipe_q[16].g10, pipe_q[16].nx);
    pipe_d[17].pp[7] = rpp_pkg::qmul_pp(pipe_q[16].g11, pipe_q[16].ny);

    pipe_d[18].j0 = rpp_pkg::qmul_fin(pipe_q[17].pp[0]);
    pipe_d[18].j1 = rpp_pkg::qmul_fin(pipe_q[17].pp[1]);
    pipe_d[18].j2 = rpp_pkg::qmul_fin(pipe_q[17].pp[2]);
    pipe_d[18].j3 = rpp_pkg::qmul_fin(pipe_q[17].pp[3]);
    pipe_d[18].j4 = rpp_pkg::qmul_fin(pipe_q[17].pp[4]);
    pipe_d[18].j5 = rpp_pkg::qmul_fin(pipe_q[17].pp[5]);
    pipe_d[18].j6 = rpp_pkg::qmul_fin(pipe_q[17].pp[6]);
    pipe_d[18].j7 = rpp_pkg::qmul_fin(pipe_q[17].pp[7]);
    pipe_d[18].inimg = !pipe_q[17].pu[31] && !pipe_q[17].pv[31]
      && ($signed({{17{pipe_q[17].pu[31]}}, pipe_q[17].pu}) <= rpp_pkg::IMG_U_MAX)
      && ($signed({{17{pipe_q[17].pv[31]}}, pipe_q[17].pv}) <= rpp_pkg::IMG_V_MAX);

    // output register; a non-positive depth gives an all-zero item
    if (pipe_q[18].ok) begin
      pipe_d[19].ju_x = rpp_pkg::to_q16(pipe_q[18].j0);
      pipe_d[19].ju_y = rpp_pkg::to_q16(pipe_q[18].j1);
      pipe_d[19].ju_z = rpp_pkg::to_q16(rpp_pkg::qadd(pipe_q[18].j2, pipe_q[18].j3));
      pipe_d[19].jv_x = rpp_pkg::to_q16(pipe_q[18].j4);
      pipe_d[19].jv_y = rpp_pkg::to_q16(pipe_q[18].j5);
      pipe_d[19].jv_z = rpp_pkg::to_q16(rpp_pkg::qadd(pipe_q[18].j6, pipe_q[18].j7));
    end else begin
      pipe_d[19].pu    = '0;
      pipe_d[19].pv    = '0;
      pipe_d[19].inimg = 1'b0;
      pipe_d[19].ju_x  = '0;
      pipe_d[19].ju_y  = '0;
      pipe_d[19].ju_z  = '0;
      pipe_d[19].jv_x  = '0;
      pipe_d[19].jv_y  = '0;
      pipe_d[19].jv_z  = '0;
    end
  end

  assign res_o.valid     = vld_q[rpp_pkg::PIPE_N-1];
  assign res_o.valid_res = pipe_q[rpp_pkg::PIPE_N-1].ok;
  assign res_o.pixel_u   = pipe_q[rpp_pkg::PIPE_N-1].pu;
  assign res_o.pixel_v   = pipe_q[rpp_pkg::PIPE_N-1].pv;
  assign res_o.in_image  = pipe_q[rpp_pkg::PIPE_N-1].inimg;
  assign res_o.jac_u_x   = pipe_q[rpp_pkg::PIPE_N-1].ju_x;
  assign res_o.jac_u_y   = pipe_q[rpp_pkg::PIPE_N-1].ju_y;
  assign res_o.jac_u_z   = pipe_q[rpp_pkg::PIPE_N-1].ju_z;
  assign res_o.jac_v_x   = pipe_q[rpp_pkg::PIPE_N-1].jv_x;
  assign res_o.jac_v_y   = pipe_q[rpp_pkg::PIPE_N-1].jv_y;
  assign res_o.jac_v_z   = pipe_q[rpp_pkg::PIPE_N-1].jv_z;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.valid_res |-> res_o.pixel_u == 0 && res_o.pixel_v == 0
      && !res_o.in_image && res_o.jac_u_x == 0 && res_o.jac_v_z == 0)
    else $error("invalid item carries nonzero fields");

  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.in_image |-> res_o.valid_res && !res_o.pixel_u[31]
      && !res_o.pixel_v[31])
    else $error("in_image set on an invalid or negative pixel");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pnt_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without a held output item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(vdiv_q))
    else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire

### tb/rpp_tb_ifs.sv
// testbench helper: the item record that the projection checker keeps per result, and the point record
`timescale 1ns / 1ps
package rpp_tb_pkg;
  typedef struct {
    logic               valid_res;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               in_image;
    logic signed [31:0] jac_u_x;
    logic signed [31:0] jac_u_y;
    logic signed [31:0] jac_u_z;
    logic signed [31:0] jac_v_x;
    logic signed [31:0] jac_v_y;
    logic signed [31:0] jac_v_z;
  } proj_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;
endpackage

### tb/radtan_point_projection_tb.sv
// testbench: random and directed points against a bit-exact projection predictor
`timescale 1ns / 1ps
module radtan_point_projection_tb;

  localparam longint QC = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int LIMIT = 2000000;
  localparam logic [rpp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rpp_cfg_if cfg_if ();
  rpp_in_if  pnt_if ();
  rpp_out_if res_if ();

  radtan_point_projection u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .pnt_i  (pnt_if.sink),
    .res_o  (res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0]          cam_regs [8];
  rpp_tb_pkg::point_t   point_queue [$];
  rpp_tb_pkg::proj_t    proj_queue [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_off = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;

  function automatic longint sat_sm(bit neg, logic [63:0] m);
    if (m > 64'(QC)) m = 64'(QC);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] mag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint sadd(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(QC)) return QC;
    if (s < -65'(QC)) return -QC;
    return longint'(s);
  endfunction

  function automatic longint smul(longint a, longint b);
    logic [63:0] ma, mb;
    logic [127:0] p;
    ma = mag(a);
    mb = mag(b);
    p = (128'(ma) * 128'(mb)) >> 32;
    return sat_sm((a < 0) != (b < 0), p > 128'(QC) ? 64'(QC) : p[63:0]);
  endfunction

  function automatic longint sdiv(longint num, longint den);
    logic [95:0] m;
    m = (96'(mag(num)) << 32) / 96'(den);
    return sat_sm(num < 0, m > 96'(QC) ? 64'(QC) : m[63:0]);
  endfunction

  function automatic logic signed [31:0] q16(longint a);
    logic [63:0] m;
    m = mag(a) >> 16;
    if (a < 0) return (m > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
    return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
  endfunction

  function automatic rpp_tb_pkg::proj_t project_point(rpp_tb_pkg::point_t p);
    rpp_tb_pkg::proj_t r;
    longint fx, fy, cx, cy, k1, k2, p1, p2, two, four, six, one;
    longint xn, yn, x2, y2, xy, r2, rad, xd, yd;
    longint d00, d01, d11, iz, nx, ny, g00, g01, g10, g11;
    logic signed [31:0] pu, pv;
    r = '{default: 0};
    if (p.z <= 0) return r;
    one = 64'sh1_0000_0000;
    two = 2 * one;
    four = 4 * one;
    six = 6 * one;
    fx = longint'({32'b0, cam_regs[0]}) << 16;
    fy = longint'({32'b0, cam_regs[1]}) << 16;
    cx = longint'($signed(cam_regs[2])) * 65536;
    cy = longint'($signed(cam_regs[3])) * 65536;
    k1 = longint'($signed(cam_regs[4])) * 16;
    k2 = longint'($signed(cam_regs[5])) * 16;
    p1 = longint'($signed(cam_regs[6])) * 16;
    p2 = longint'($signed(cam_regs[7])) * 16;
    xn = sdiv(p.x, p.z);
    yn = sdiv(p.y, p.z);
    x2 = smul(xn, xn);
    y2 = smul(yn, yn);
    xy = smul(xn, yn);
    r2 = sadd(x2, y2);
    rad = sadd(smul(k1, r2), smul(smul(k2, r2), r2));
    xd = xn;
    yd = yn;
    if (k1 > 0 && k2 > 0 && p1 > 0 && p2 > 0) begin
      xd = sadd(xn, sadd(sadd(smul(xn, rad), smul(smul(two, p1), xy)),
                         smul(p2, sadd(r2, smul(two, x2)))));
      yd = sadd(yn, sadd(sadd(smul(yn, rad), smul(smul(two, p2), xy)),
                         smul(p1, sadd(r2, smul(two, y2)))));
    end
    pu = q16(sadd(smul(fx, xd), cx));
    pv = q16(sadd(smul(fy, yd), cy));
    d00 = sadd(sadd(sadd(sadd(sadd(one, rad), smul(smul(two, k1), x2)),
                         smul(smul(smul(four, k2), r2), x2)),
                    smul(smul(two, p1), yn)), smul(smul(six, p2), xn));
    d01 = sadd(sadd(sadd(smul(smul(two, k1), xy), smul(smul(smul(four, k2), r2), xy)),
                    smul(smul(two, p1), xn)), smul(smul(two, p2), yn));
    d11 = sadd(sadd(sadd(sadd(sadd(one, rad), smul(smul(two, k1), y2)),
                         smul(smul(smul(four, k2), r2), y2)),
                    smul(smul(two, p2), xn)), smul(smul(six, p1), yn));
    iz = sdiv(65536, p.z);
    nx = -smul(xn, iz);
    ny = -smul(yn, iz);
    g00 = smul(fx, d00);
    g01 = smul(fx, d01);
    g10 = smul(fy, d01);
    g11 = smul(fy, d11);
    r.valid_res = 1'b1;
    r.pixel_u = pu;
    r.pixel_v = pv;
    r.in_image = (pu >= 0 && pu <= (rpp_pkg::IMG_COLS - 1) * 65536 &&
                  pv >= 0 && pv <= (rpp_pkg::IMG_ROWS - 1) * 65536);
    r.jac_u_x = q16(smul(g00, iz));
    r.jac_u_y = q16(smul(g01, iz));
    r.jac_u_z = q16(sadd(smul(g00, nx), smul(g01, ny)));
    r.jac_v_x = q16(smul(g10, iz));
    r.jac_v_y = q16(smul(g11, iz));
    r.jac_v_z = q16(sadd(smul(g10, nx), smul(g11, ny)));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic write_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx < 8) cam_regs[idx[2:0]] = val;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_wait();
    while (point_queue.size() != 0 || pnt_if.valid || proj_queue.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic rpp_tb_pkg::point_t scene_point();
    rpp_tb_pkg::point_t p;
    if ($urandom_range(0, 9) == 0) begin
      p.x = edge_word();
      p.y = edge_word();
      p.z = edge_word();
    end else begin
      p.z = $urandom_range(16'h4000, 32'h00FF_FFFF);
      p.x = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF;
      p.y = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh00FF_FFFF;
      if ($urandom_range(0, 15) == 0) p.z = -$signed($urandom_range(0, 1000));
    end
    return p;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnt_if.valid <= 1'b0;
      pnt_if.point_x <= '0;
      pnt_if.point_y <= '0;
      pnt_if.point_z <= '0;
    end else begin
      if (pnt_if.valid && pnt_if.ready) begin
        proj_queue.push_back(project_point(point_queue.pop_front()));
      end
      if (pnt_if.valid && !pnt_if.ready) begin
        // item waits
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        pnt_if.valid <= 1'b0;
      end else if (pnt_if.valid && burst_left == 0 && gaps_on) begin
        burst_left <= $urandom_range(0, 30);
        gap_left <= $urandom_range(0, 6);
        pnt_if.valid <= 1'b0;
      end else if (point_queue.size() != 0) begin
        pnt_if.valid <= 1'b1;
        pnt_if.point_x <= point_queue[0].x;
        pnt_if.point_y <= point_queue[0].y;
        pnt_if.point_z <= point_queue[0].z;
        if (pnt_if.valid && burst_left > 0) burst_left <= burst_left - 1;
      end else begin
        pnt_if.valid <= 1'b0;
      end
    end
  end

  // output ready pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !stall_on || ($urandom_range(0, 3) != 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (proj_queue.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        rpp_tb_pkg::proj_t e;
        e = proj_queue.pop_front();
        if (res_if.valid_res !== e.valid_res) report_mismatch("valid_res", res_if.valid_res, e.valid_res);
        if (res_if.pixel_u !== e.pixel_u) report_mismatch("pixel_u", res_if.pixel_u, e.pixel_u);
        if (res_if.pixel_v !== e.pixel_v) report_mismatch("pixel_v", res_if.pixel_v, e.pixel_v);
        if (res_if.in_image !== e.in_image) report_mismatch("in_image", res_if.in_image, e.in_image);
        if (res_if.jac_u_x !== e.jac_u_x) report_mismatch("jac_u_x", res_if.jac_u_x, e.jac_u_x);
        if (res_if.jac_u_y !== e.jac_u_y) report_mismatch("jac_u_y", res_if.jac_u_y, e.jac_u_y);
        if (res_if.jac_u_z !== e.jac_u_z) report_mismatch("jac_u_z", res_if.jac_u_z, e.jac_u_z);
        if (res_if.jac_v_x !== e.jac_v_x) report_mismatch("jac_v_x", res_if.jac_v_x, e.jac_v_x);
        if (res_if.jac_v_y !== e.jac_v_y) report_mismatch("jac_v_y", res_if.jac_v_y, e.jac_v_y);
        if (res_if.jac_v_z !== e.jac_v_z) report_mismatch("jac_v_z", res_if.jac_v_z, e.jac_v_z);
      end
    end
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rpp_tb_pkg::point_t p;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (cam_regs[i]) cam_regs[i] = '0;
    cam_regs[0] = rpp_pkg::FOCAL_RESET;
    cam_regs[1] = rpp_pkg::FOCAL_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed points at reset settings
    point_queue.push_back('{32'sd0, 32'sd0, 32'sd0});
    point_queue.push_back('{32'sd1, 32'sd1, -32'sd1});
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000});
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1});
    point_queue.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    point_queue.push_back('{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000});
    point_queue.push_back('{32'sd0, 32'sd0, 32'sh7FFF_FFFF});
    point_queue.push_back('{-32'sd1, -32'sd1, 32'sd1});
    drain_wait();

    // image plane setup with positive distortion
    write_reg(rpp_pkg::REG_FOCAL_X, 32'd500 << 16);
    write_reg(rpp_pkg::REG_FOCAL_Y, 32'd480 << 16);
    write_reg(rpp_pkg::REG_CENTER_X, 32'd512 << 16);
    write_reg(rpp_pkg::REG_CENTER_Y, 32'd384 << 16);
    write_reg(rpp_pkg::REG_RADIAL_K1, 32'h0100_0000);
    write_reg(rpp_pkg::REG_RADIAL_K2, 32'h0080_0000);
    write_reg(rpp_pkg::REG_TANG_P1, 32'h0010_0000);
    write_reg(rpp_pkg::REG_TANG_P2, 32'h0020_0000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    point_queue.push_back('{32'sd0, 32'sd0, 32'sh0001_0000});
    point_queue.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    point_queue.push_back('{-32'sh0004_0000, 32'sh0003_0000, 32'sh0002_0000});
    point_queue.push_back('{32'sh0000_8000, -32'sh0000_8000, 32'sd1});
    for (int i = 0; i < 300; i++) point_queue.push_back(scene_point());
    // long receiver hold-off while points keep coming
    hold_off = 200;
    while (point_queue.size() != 0) @(posedge clk_i);
    drain_wait();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(rpp_pkg::REG_FOCAL_X, 32'hFFFF_FFFF);
          write_reg(rpp_pkg::REG_FOCAL_Y, 32'h0);
          write_reg(rpp_pkg::REG_CENTER_X, 32'h8000_0000);
          write_reg(rpp_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
          write_reg(rpp_pkg::REG_RADIAL_K1, 32'h7FFF_FFFF);
          write_reg(rpp_pkg::REG_RADIAL_K2, 32'h7FFF_FFFF);
          write_reg(rpp_pkg::REG_TANG_P1, 32'h7FFF_FFFF);
          write_reg(rpp_pkg::REG_TANG_P2, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(rpp_pkg::REG_RADIAL_K1, 32'h8000_0000);
          write_reg(rpp_pkg::REG_RADIAL_K2, 32'h8000_0000);
          write_reg(rpp_pkg::REG_TANG_P1, 32'h8000_0000);
          write_reg(rpp_pkg::REG_TANG_P2, 32'h8000_0000);
          write_reg(rpp_pkg::REG_FOCAL_Y, 32'hFFFF_FFFF);
        end
        default: begin
          for (int r = 0; r < 8; r++)
            write_reg(r[rpp_pkg::CFG_IDX_W-1:0],
                      ($urandom_range(0, 1) ? $urandom : edge_word()));
          if (phase == 4) begin
            write_reg(rpp_pkg::REG_RADIAL_K1, $urandom_range(1, 32'h0200_0000));
            write_reg(rpp_pkg::REG_RADIAL_K2, $urandom_range(1, 32'h0200_0000));
            write_reg(rpp_pkg::REG_TANG_P1, $urandom_range(1, 32'h0100_0000));
            write_reg(rpp_pkg::REG_TANG_P2, $urandom_range(1, 32'h0100_0000));
            write_reg(rpp_pkg::REG_FOCAL_X, $urandom_range(1, 1000) << 16);
            write_reg(rpp_pkg::REG_FOCAL_Y, $urandom_range(1, 1000) << 16);
          end
        end
      endcase
      gaps_on = (phase != 3);
      stall_on = (phase != 2);
      for (int i = 0; i < 260; i++) begin
        p = scene_point();
        point_queue.push_back(p);
      end
      while (point_queue.size() != 0) @(posedge clk_i);
      drain_wait();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
